FILE: design/prx_pkg.sv
// Shared types and constants for the proxy number allocator and table.
// No dependencies; every other design file imports this package.
`timescale 1ns / 1ps
package prx_pkg;

  localparam int NODE_W   = 16;
  localparam int PID_W    = 31;
  localparam int PRIO_W   = 8;
  localparam int SLOT_W   = 11;
  localparam int BIT_W    = 5;
  localparam int WADDR_W  = SLOT_W - BIT_W;
  localparam int WORD_W   = 1 << BIT_W;
  localparam int ID_SHIFT = 16;
  localparam int NEWID_W  = SLOT_W + ID_SHIFT;
  localparam int ADDR_W   = NODE_W + PID_W;

  typedef enum logic [1:0] {
    CMD_ATTACH = 2'd0,
    CMD_DETACH = 2'd1,
    CMD_TRIGGER = 2'd2,
    CMD_CLOSE = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0,
    ST_NO_ID = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_NOT_OWNER = 2'd3
  } status_t;

  typedef struct packed {
    logic [ADDR_W-1:0] target;
    logic [ADDR_W-1:0] creator;
    logic [PRIO_W-1:0] prio;
  } entry_t;

  typedef struct packed {
    logic               re;
    logic [WADDR_W-1:0] raddr;
    logic               we;
    logic [WADDR_W-1:0] waddr;
    logic [WORD_W-1:0]  wdata;
  } bm_req_t;

  typedef struct packed {
    logic              re;
    logic [SLOT_W-1:0] raddr;
    logic              we;
    logic [SLOT_W-1:0] waddr;
    entry_t            wdata;
  } ent_req_t;

endpackage

FILE: design/prx_bitmap_ram.sv
// Occupancy bitmap memory: one bit per proxy number, 32 numbers per word.
// Depends on prx_pkg for the request type.
`timescale 1ns / 1ps
module prx_bitmap_ram
  import prx_pkg::*;
(
  input  logic              clk,
  input  bm_req_t           req,
  output logic [WORD_W-1:0] rdata
);

  logic [WORD_W-1:0] mem [0:(1<<WADDR_W)-1];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

FILE: design/prx_entry_ram.sv
// Proxy table memory holding target, creator and priority of each number.
// Depends on prx_pkg for the entry and request types.
`timescale 1ns / 1ps
module prx_entry_ram
  import prx_pkg::*;
(
  input  logic     clk,
  input  ent_req_t req,
  output entry_t   rdata
);

  entry_t mem [0:(1<<SLOT_W)-1];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

FILE: design/prx_ctrl.sv
// Command sequencer: bitmap clear after reset, lowest free search, lookup and close scan.
// Depends on prx_pkg; drives prx_bitmap_ram and prx_entry_ram.
`timescale 1ns / 1ps
module prx_ctrl
  import prx_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_cmd,
  input  logic [30:0]        in_proxy_id,
  input  logic [NODE_W-1:0]  in_target_node,
  input  logic [PID_W-1:0]   in_target_pid,
  input  logic [NODE_W-1:0]  in_caller_node,
  input  logic [PID_W-1:0]   in_caller_pid,
  input  logic [PRIO_W-1:0]  in_priority_req,
  output bm_req_t            bm_req,
  input  logic [WORD_W-1:0]  bm_rdata,
  output ent_req_t           ent_req,
  input  entry_t             ent_rdata,
  output logic               out_valid,
  output logic [1:0]         out_status,
  output logic [NEWID_W-1:0] out_new_proxy_id,
  output logic [NODE_W-1:0]  out_found_node,
  output logic [PID_W-1:0]   out_found_pid,
  output logic [PRIO_W-1:0]  out_found_priority
);

  typedef enum logic [2:0] {
    S_CLR, S_IDLE, S_ATT, S_LOOK, S_CW, S_CE
  } state_t;

  state_t              state_r;
  cmd_t                cmd_r;
  logic [WADDR_W-1:0]  w_r;
  logic [BIT_W-1:0]    j_r;
  logic [SLOT_W-1:0]   slot_r;
  logic [ADDR_W-1:0]   target_r;
  logic [ADDR_W-1:0]   caller_r;
  logic [PRIO_W-1:0]   prio_r;
  logic [WORD_W-1:0]   word_r;

  logic                accept;
  logic [WORD_W-1:0]   masked;
  logic                att_hit;
  logic [BIT_W-1:0]    att_bit;
  logic                sel_valid;
  logic                ce_hit;
  logic [WORD_W-1:0]   ce_word;
  logic [SLOT_W-1:0]   in_slot;

  assign busy    = (state_r != S_IDLE);
  assign accept  = start && !busy;
  assign in_slot = in_proxy_id[ID_SHIFT +: SLOT_W];

  always_comb begin
    masked = bm_rdata | {{(WORD_W-1){1'b0}}, (w_r == '0)};
    att_hit = ~&masked;
    att_bit = '0;
    for (int k = WORD_W - 1; k >= 0; k--) begin
      if (!masked[k]) begin
        att_bit = BIT_W'(k);
      end
    end
    sel_valid = bm_rdata[slot_r[BIT_W-1:0]];
    ce_hit = word_r[j_r] && (ent_rdata.target == target_r);
    ce_word = word_r & ~(WORD_W'(ce_hit) << j_r);
  end

  always_comb begin
    bm_req = '0;
    ent_req = '0;
    ent_req.wdata = '{target: target_r, creator: caller_r, prio: prio_r};
    case (state_r)
      S_CLR: begin
        bm_req.we = 1'b1;
        bm_req.waddr = w_r;
      end
      S_IDLE: begin
        if (accept) begin
          bm_req.re = 1'b1;
          ent_req.re = 1'b1;
          ent_req.raddr = in_slot;
          if (cmd_t'(in_cmd) == CMD_DETACH || cmd_t'(in_cmd) == CMD_TRIGGER) begin
            bm_req.raddr = in_slot[SLOT_W-1:BIT_W];
          end
        end
      end
      S_ATT: begin
        if (att_hit) begin
          bm_req.we = 1'b1;
          bm_req.waddr = w_r;
          bm_req.wdata = bm_rdata | (WORD_W'(1) << att_bit);
          ent_req.we = 1'b1;
          ent_req.waddr = {w_r, att_bit};
        end else begin
          bm_req.re = 1'b1;
          bm_req.raddr = w_r + 1'b1;
        end
      end
      S_LOOK: begin
        if (cmd_r == CMD_DETACH && sel_valid && ent_rdata.creator == caller_r) begin
          bm_req.we = 1'b1;
          bm_req.waddr = slot_r[SLOT_W-1:BIT_W];
          bm_req.wdata = bm_rdata & ~(WORD_W'(1) << slot_r[BIT_W-1:0]);
        end
      end
      S_CW: begin
        ent_req.re = 1'b1;
        ent_req.raddr = {w_r, {BIT_W{1'b0}}};
      end
      S_CE: begin
        if (j_r != {BIT_W{1'b1}}) begin
          ent_req.re = 1'b1;
          ent_req.raddr = {w_r, j_r + 1'b1};
        end else begin
          bm_req.we = 1'b1;
          bm_req.waddr = w_r;
          bm_req.wdata = ce_word;
          bm_req.re = 1'b1;
          bm_req.raddr = w_r + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      w_r <= '0;
      j_r <= '0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      case (state_r)
        S_CLR: begin
          w_r <= w_r + 1'b1;
          if (w_r == {WADDR_W{1'b1}}) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            cmd_r <= cmd_t'(in_cmd);
            slot_r <= in_slot;
            target_r <= {in_target_node, in_target_pid};
            caller_r <= {in_caller_node, in_caller_pid};
            prio_r <= in_priority_req;
            w_r <= '0;
            case (cmd_t'(in_cmd))
              CMD_ATTACH: state_r <= S_ATT;
              CMD_CLOSE:  state_r <= S_CW;
              default:    state_r <= S_LOOK;
            endcase
          end
        end
        S_ATT: begin
          out_status <= ST_OK;
          out_new_proxy_id <= '0;
          out_found_node <= '0;
          out_found_pid <= '0;
          out_found_priority <= '0;
          if (att_hit) begin
            out_valid <= 1'b1;
            out_new_proxy_id <= {w_r, att_bit, {ID_SHIFT{1'b0}}};
            state_r <= S_IDLE;
          end else if (w_r == {WADDR_W{1'b1}}) begin
            out_valid <= 1'b1;
            out_status <= ST_NO_ID;
            state_r <= S_IDLE;
          end else begin
            w_r <= w_r + 1'b1;
          end
        end
        S_LOOK: begin
          out_valid <= 1'b1;
          out_new_proxy_id <= '0;
          out_found_node <= '0;
          out_found_pid <= '0;
          out_found_priority <= '0;
          state_r <= S_IDLE;
          if (!sel_valid) begin
            out_status <= ST_NOT_FOUND;
          end else if (cmd_r == CMD_TRIGGER) begin
            out_status <= ST_OK;
            out_found_node <= ent_rdata.target[ADDR_W-1:PID_W];
            out_found_pid <= ent_rdata.target[PID_W-1:0];
            out_found_priority <= ent_rdata.prio;
          end else if (ent_rdata.creator != caller_r) begin
            out_status <= ST_NOT_OWNER;
          end else begin
            out_status <= ST_OK;
          end
        end
        S_CW: begin
          word_r <= bm_rdata;
          j_r <= '0;
          state_r <= S_CE;
        end
        S_CE: begin
          word_r <= ce_word;
          j_r <= j_r + 1'b1;
          if (j_r == {BIT_W{1'b1}}) begin
            if (w_r == {WADDR_W{1'b1}}) begin
              out_valid <= 1'b1;
              out_status <= ST_OK;
              out_new_proxy_id <= '0;
              out_found_node <= '0;
              out_found_pid <= '0;
              out_found_priority <= '0;
              state_r <= S_IDLE;
            end else begin
              w_r <= w_r + 1'b1;
              state_r <= S_CW;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: design/proxy_id_allocator_table_top.sv
// Top level of the proxy number allocator and table.
// Depends on prx_pkg, prx_bitmap_ram, prx_entry_ram and prx_ctrl.
//
//   Channel   Handshake               Transfer when
//   in_*      start / busy            start high and busy low
//   out_*     out_valid strobe        out_valid high (one cycle, no stall)
//
// Attach searches the bitmap memory one 32-bit word a cycle for the lowest free number.
// Detach and trigger do one registered read of each memory.
// Close reads every table entry through the single read port.
// After reset a clearing pass runs over the bitmap memory with busy high.
// The receiver cannot stall; each result is shown for exactly one cycle.
`timescale 1ns / 1ps
module proxy_id_allocator_table_top
  import prx_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_cmd,
  input  logic [30:0]        in_proxy_id,
  input  logic [NODE_W-1:0]  in_target_node,
  input  logic [PID_W-1:0]   in_target_pid,
  input  logic [NODE_W-1:0]  in_caller_node,
  input  logic [PID_W-1:0]   in_caller_pid,
  input  logic [PRIO_W-1:0]  in_priority_req,
  output logic               out_valid,
  output logic [1:0]         out_status,
  output logic [NEWID_W-1:0] out_new_proxy_id,
  output logic [NODE_W-1:0]  out_found_node,
  output logic [PID_W-1:0]   out_found_pid,
  output logic [PRIO_W-1:0]  out_found_priority
);

  bm_req_t           bm_req;
  logic [WORD_W-1:0] bm_rdata;
  ent_req_t          ent_req;
  entry_t            ent_rdata;

  prx_bitmap_ram u_bitmap (
    .clk   (clk),
    .req   (bm_req),
    .rdata (bm_rdata)
  );

  prx_entry_ram u_entry (
    .clk   (clk),
    .req   (ent_req),
    .rdata (ent_rdata)
  );

  prx_ctrl u_ctrl (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_cmd             (in_cmd),
    .in_proxy_id        (in_proxy_id),
    .in_target_node     (in_target_node),
    .in_target_pid      (in_target_pid),
    .in_caller_node     (in_caller_node),
    .in_caller_pid      (in_caller_pid),
    .in_priority_req    (in_priority_req),
    .bm_req             (bm_req),
    .bm_rdata           (bm_rdata),
    .ent_req            (ent_req),
    .ent_rdata          (ent_rdata),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_new_proxy_id   (out_new_proxy_id),
    .out_found_node     (out_found_node),
    .out_found_pid      (out_found_pid),
    .out_found_priority (out_found_priority)
  );

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("accepted command did not raise busy");

  a_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy)) else $error("result without a command in flight");

  a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("more than one result for a command");

  a_id_on_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_new_proxy_id == '0)
    else $error("proxy id returned with a failing status");

endmodule

FILE: tb/proxy_id_allocator_table_top_tb.sv
// Self-checking testbench for the proxy number allocator and table.
// Depends on prx_pkg and proxy_id_allocator_table_top; a scoreboard class predicts each result.
`timescale 1ns / 1ps
module proxy_id_allocator_table_top_tb;
  import prx_pkg::*;

  typedef struct {
    cmd_t              cmd;
    logic [30:0]       proxy_id;
    logic [NODE_W-1:0] target_node;
    logic [PID_W-1:0]  target_pid;
    logic [NODE_W-1:0] caller_node;
    logic [PID_W-1:0]  caller_pid;
    logic [PRIO_W-1:0] prio;
  } proxy_req_t;

  typedef struct {
    status_t            status;
    logic [NEWID_W-1:0] new_id;
    logic [NODE_W-1:0]  node;
    logic [PID_W-1:0]   pid;
    logic [PRIO_W-1:0]  prio;
  } proxy_rsp_t;

  localparam int NUM_SLOTS = 2048;
  localparam int MAX_NUM   = 2047;

  class proxy_table_scoreboard;
    bit                free_num[NUM_SLOTS];
    bit                live[NUM_SLOTS];
    logic [ADDR_W-1:0] target_of[NUM_SLOTS];
    logic [ADDR_W-1:0] creator_of[NUM_SLOTS];
    logic [PRIO_W-1:0] prio_of[NUM_SLOTS];
    proxy_rsp_t        awaited[$];
    int                errors;
    int                status_seen[4];

    function new();
      for (int i = 0; i < NUM_SLOTS; i++) begin
        free_num[i] = (i >= 1 && i <= MAX_NUM);
        live[i] = 1'b0;
      end
      errors = 0;
    endfunction

    function void note_request(proxy_req_t r);
      proxy_rsp_t        e;
      logic [SLOT_W-1:0] slot;
      logic [ADDR_W-1:0] tgt;
      logic [ADDR_W-1:0] clr;
      int                n;
      e = '{ST_OK, '0, '0, '0, '0};
      slot = r.proxy_id[ID_SHIFT +: SLOT_W];
      tgt = {r.target_node, r.target_pid};
      clr = {r.caller_node, r.caller_pid};
      case (r.cmd)
        CMD_ATTACH: begin
          n = 0;
          for (int i = 1; i <= MAX_NUM; i++) begin
            if (free_num[i]) begin
              n = i;
              break;
            end
          end
          if (n == 0) begin
            e.status = ST_NO_ID;
          end else begin
            free_num[n] = 1'b0;
            live[n] = 1'b1;
            target_of[n] = tgt;
            creator_of[n] = clr;
            prio_of[n] = r.prio;
            e.new_id = NEWID_W'(n) << ID_SHIFT;
          end
        end
        CMD_DETACH: begin
          if (!live[slot]) begin
            e.status = ST_NOT_FOUND;
          end else if (creator_of[slot] != clr) begin
            e.status = ST_NOT_OWNER;
          end else begin
            live[slot] = 1'b0;
            if (slot != 0) free_num[slot] = 1'b1;
          end
        end
        CMD_TRIGGER: begin
          if (!live[slot]) begin
            e.status = ST_NOT_FOUND;
          end else begin
            {e.node, e.pid} = target_of[slot];
            e.prio = prio_of[slot];
          end
        end
        default: begin
          for (int i = 0; i < NUM_SLOTS; i++) begin
            if (live[i] && target_of[i] == tgt) begin
              live[i] = 1'b0;
              if (i != 0) free_num[i] = 1'b1;
            end
          end
        end
      endcase
      awaited.push_back(e);
    endfunction

    function void check_result(proxy_rsp_t a);
      proxy_rsp_t e;
      if (awaited.size() == 0) begin
        $error("result with nothing awaited: status %0d", a.status);
        errors++;
        return;
      end
      e = awaited.pop_front();
      status_seen[e.status]++;
      if (a.status !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, a.status);
        errors++;
      end
      if (a.new_id !== e.new_id) begin
        $error("new_proxy_id: expected %h, got %h", e.new_id, a.new_id);
        errors++;
      end
      if (a.node !== e.node) begin
        $error("found_node: expected %h, got %h", e.node, a.node);
        errors++;
      end
      if (a.pid !== e.pid) begin
        $error("found_pid: expected %h, got %h", e.pid, a.pid);
        errors++;
      end
      if (a.prio !== e.prio) begin
        $error("found_priority: expected %h, got %h", e.prio, a.prio);
        errors++;
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         in_cmd = '0;
  logic [30:0]        in_proxy_id = '0;
  logic [NODE_W-1:0]  in_target_node = '0;
  logic [PID_W-1:0]   in_target_pid = '0;
  logic [NODE_W-1:0]  in_caller_node = '0;
  logic [PID_W-1:0]   in_caller_pid = '0;
  logic [PRIO_W-1:0]  in_priority_req = '0;
  logic               out_valid;
  logic [1:0]         out_status;
  logic [NEWID_W-1:0] out_new_proxy_id;
  logic [NODE_W-1:0]  out_found_node;
  logic [PID_W-1:0]   out_found_pid;
  logic [PRIO_W-1:0]  out_found_priority;

  proxy_table_scoreboard sb = new();
  bit                    no_idle = 1'b0;
  int                    quiet_cycles = 0;
  int                    cmd_sent[4];

  always #10 clk = ~clk;

  proxy_id_allocator_table_top dut (.*);

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      sb.check_result('{status_t'(out_status), out_new_proxy_id, out_found_node,
                        out_found_pid, out_found_priority});
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 20000) begin
      $display("proxy_id_allocator_table_top: mismatch");
      $finish;
    end
  end

  task automatic send(proxy_req_t r);
    @(negedge clk);
    while (!no_idle && $urandom_range(99) < 7) begin
      start = 1'b0;
      @(negedge clk);
    end
    start = 1'b1;
    in_cmd = r.cmd;
    in_proxy_id = r.proxy_id;
    in_target_node = r.target_node;
    in_target_pid = r.target_pid;
    in_caller_node = r.caller_node;
    in_caller_pid = r.caller_pid;
    in_priority_req = r.prio;
    do @(posedge clk); while (busy);
    sb.note_request(r);
    cmd_sent[r.cmd]++;
  endtask

  function automatic proxy_req_t mk(cmd_t c, int slot, logic [NODE_W-1:0] tn,
                                    logic [PID_W-1:0] tp, logic [NODE_W-1:0] cn,
                                    logic [PID_W-1:0] cp, logic [PRIO_W-1:0] pr);
    proxy_req_t r;
    r.cmd = c;
    r.proxy_id = {4'($urandom), SLOT_W'(slot), 16'($urandom)};
    r.target_node = tn;
    r.target_pid = tp;
    r.caller_node = cn;
    r.caller_pid = cp;
    r.prio = pr;
    return r;
  endfunction

  function automatic logic [NODE_W-1:0] pick_node();
    if ($urandom_range(3) == 0) return 16'($urandom);
    return NODE_W'($urandom_range(2));
  endfunction

  function automatic logic [PID_W-1:0] pick_pid();
    if ($urandom_range(3) == 0) return 31'($urandom);
    return $urandom_range(2) == 0 ? 31'h7fffffff : PID_W'($urandom_range(3));
  endfunction

  function automatic int pick_live();
    int slots[$];
    for (int i = 1; i < NUM_SLOTS; i++) if (sb.live[i]) slots.push_back(i);
    if (slots.size() == 0) return $urandom_range(NUM_SLOTS - 1);
    return slots[$urandom_range(slots.size() - 1)];
  endfunction

  function automatic proxy_req_t random_req();
    proxy_req_t r;
    int         roll;
    int         s;
    roll = $urandom_range(99);
    r = mk(CMD_ATTACH, 0, pick_node(), pick_pid(), pick_node(), pick_pid(), 8'($urandom));
    if (roll < 35) return r;
    s = pick_live();
    if (roll < 65) begin
      r.cmd = CMD_DETACH;
      r.proxy_id[ID_SHIFT +: SLOT_W] = SLOT_W'(s);
      if ($urandom_range(99) < 70 && sb.live[s]) begin
        {r.caller_node, r.caller_pid} = sb.creator_of[s];
      end else if ($urandom_range(1) == 0) begin
        r.proxy_id = 31'($urandom);
      end
    end else if (roll < 93) begin
      r.cmd = CMD_TRIGGER;
      r.proxy_id[ID_SHIFT +: SLOT_W] = SLOT_W'(s);
      if ($urandom_range(9) == 0) r.proxy_id = 31'($urandom);
    end else begin
      r.cmd = CMD_CLOSE;
      if (sb.live[s] && $urandom_range(3) != 0) begin
        {r.target_node, r.target_pid} = sb.target_of[s];
      end
    end
    return r;
  endfunction

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send(mk(CMD_ATTACH, 0, '0, '0, '0, '0, '0));
    send(mk(CMD_ATTACH, 0, '1, '1, '1, '1, '1));
    send(mk(CMD_ATTACH, 0, 16'h5a5a, 31'h2aaa5555, 16'h0001, 31'h1, 8'h80));
    send(mk(CMD_TRIGGER, 1, '0, '0, '0, '0, '0));
    send(mk(CMD_TRIGGER, 2, '0, '0, '0, '0, '0));
    send(mk(CMD_TRIGGER, 0, '0, '0, '0, '0, '0));
    send(mk(CMD_TRIGGER, 2047, '0, '0, '0, '0, '0));
    send(mk(CMD_DETACH, 2, '0, '0, 16'hfffe, '1, '0));
    send(mk(CMD_DETACH, 2, '0, '0, '1, '1, '0));
    send(mk(CMD_DETACH, 2, '0, '0, '1, '1, '0));
    send(mk(CMD_DETACH, 0, '0, '0, '0, '0, '0));
    send(mk(CMD_ATTACH, 0, 16'h5a5a, 31'h2aaa5555, '1, '1, 8'h01));
    send(mk(CMD_TRIGGER, 2, '0, '0, '0, '0, '0));
    send(mk(CMD_CLOSE, 0, 16'h1234, 31'h1234, '0, '0, '0));
    send(mk(CMD_CLOSE, 0, 16'h5a5a, 31'h2aaa5555, '0, '0, '0));
    send(mk(CMD_TRIGGER, 3, '0, '0, '0, '0, '0));
    send(mk(CMD_DETACH, 1, '0, '0, '0, '0, '0));

    for (int k = 0; k < 400; k++) begin
      no_idle = (k >= 120 && k < 220);
      send(random_req());
    end

    send(mk(CMD_TRIGGER, 2047, '0, '0, '0, '0, '0));
    send(mk(CMD_DETACH, pick_live(), '0, '0, '1, '1, '0));
    send(mk(CMD_CLOSE, 0, 16'h00aa, 31'h55, '0, '0, '0));
    for (int k = 0; k < 20; k++) send(random_req());

    @(negedge clk);
    start = 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("Sent %0d attach, %0d detach, %0d trigger, %0d close requests.",
             cmd_sent[CMD_ATTACH], cmd_sent[CMD_DETACH],
             cmd_sent[CMD_TRIGGER], cmd_sent[CMD_CLOSE]);
    $display("Results: %0d ok, %0d no id, %0d not found, %0d not owner.",
             sb.status_seen[ST_OK], sb.status_seen[ST_NO_ID],
             sb.status_seen[ST_NOT_FOUND], sb.status_seen[ST_NOT_OWNER]);
    if (sb.errors == 0 && sb.awaited.size() == 0) begin
      $display("proxy_id_allocator_table_top: match");
    end else begin
      $display("proxy_id_allocator_table_top: mismatch");
    end
    $finish;
  end

endmodule
